[rtl/bda_pkg.sv]
// ----------------------------------------------------------------------------
// bda_pkg
// Shared types, limits and the reciprocal table of the box downsampler.
// ----------------------------------------------------------------------------
package bda_pkg;

	// limits of the configured geometry
	localparam int unsigned MAX_WIDTH  = 4096;
	localparam int unsigned MAX_FACTOR = 16;
	localparam int unsigned ROW_LIMIT  = 4096;

	// field and counter widths
	localparam int unsigned CHAN_W   = 8;
	localparam int unsigned NCHAN    = 3;
	localparam int unsigned FACT_W   = 5;
	localparam int unsigned DIM_W    = 13;
	localparam int unsigned COL_W    = $clog2(MAX_WIDTH);
	localparam int unsigned PHASE_W  = $clog2(MAX_FACTOR);
	localparam int unsigned HSUM_W   = 12;
	localparam int unsigned CSUM_W   = 16;
	localparam int unsigned RSHIFT   = 24;
	localparam int unsigned RECIP_W  = RSHIFT + 1;

	// configuration register indexes
	typedef enum logic [1:0] {
		REG_SCALE  = 2'd0,
		REG_WIDTH  = 2'd1,
		REG_HEIGHT = 2'd2
	} reg_idx_t;

	typedef logic [NCHAN-1:0][HSUM_W-1:0] hsum_t;
	typedef logic [NCHAN-1:0][CSUM_W-1:0] csum_t;
	typedef logic [NCHAN-1:0][CHAN_W-1:0] pix_t;

	// one line store update issued by the raster front end
	typedef struct packed {
		logic             valid;
		logic [COL_W-1:0] addr;
		logic             first;
		logic             emit;
		logic             last;
		hsum_t            hsum;
	} req_t;

	// ceil(2^24 / (n*n)); exact quotient for 16-bit sums after a 24-bit shift
	function automatic logic [RECIP_W-1:0] recip(input logic [FACT_W-1:0] n);
		logic [RECIP_W-1:0] r;
		case (n)
			5'd2:    r = 25'd4194304;
			5'd3:    r = 25'd1864136;
			5'd4:    r = 25'd1048576;
			5'd5:    r = 25'd671089;
			5'd6:    r = 25'd466034;
			5'd7:    r = 25'd342393;
			5'd8:    r = 25'd262144;
			5'd9:    r = 25'd207127;
			5'd10:   r = 25'd167773;
			5'd11:   r = 25'd138655;
			5'd12:   r = 25'd116509;
			5'd13:   r = 25'd99274;
			5'd14:   r = 25'd85599;
			5'd15:   r = 25'd74566;
			5'd16:   r = 25'd65536;
			default: r = 25'd16777216;
		endcase
		return r;
	endfunction

endpackage

[rtl/bda_accum.sv]
// ----------------------------------------------------------------------------
// bda_accum
// Column sum line store with read-modify-write and the block average divide.
// ----------------------------------------------------------------------------
module bda_accum (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  adv,
	input  bda_pkg::req_t                         req,
	input  logic [bda_pkg::FACT_W-1:0]            n,
	output logic                                  res_valid,
	output logic                                  res_last,
	output bda_pkg::pix_t                         res_data
);

	localparam int unsigned PROD_W = bda_pkg::CSUM_W + bda_pkg::RECIP_W;

	bda_pkg::csum_t mem [bda_pkg::MAX_WIDTH];
	bda_pkg::csum_t rd_q;
	bda_pkg::req_t  req_s2;
	bda_pkg::csum_t sum;

	logic                            valid_s3;
	logic                            last_s3;
	bda_pkg::csum_t                  sum_s3;
	logic [bda_pkg::RECIP_W-1:0]     recip_s3;
	logic [bda_pkg::NCHAN-1:0][PROD_W-1:0] prod;

	logic                            valid_s4;
	logic                            last_s4;
	bda_pkg::pix_t                   quo_s4;

	// line store: read for the incoming update, write back the merged sum
	always_ff @(posedge clk) begin
		if (adv) begin
			rd_q <= mem[req.addr];
			if (req_s2.valid) begin
				mem[req_s2.addr] <= sum;
			end
		end
	end

	// merge: first row of a band overwrites, later rows add
	always_comb begin
		for (int k = 0; k < bda_pkg::NCHAN; k++) begin
			sum[k] = (req_s2.first ? '0 : rd_q[k])
				+ bda_pkg::CSUM_W'(req_s2.hsum[k]);
		end
	end

	// scaled products by the reciprocal of the block area
	always_comb begin
		for (int k = 0; k < bda_pkg::NCHAN; k++) begin
			prod[k] = PROD_W'(sum_s3[k]) * PROD_W'(recip_s3);
		end
	end

	// pipeline stages
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			req_s2   <= '0;
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
		end else if (adv) begin
			req_s2   <= req;
			valid_s3 <= req_s2.valid && req_s2.emit;
			valid_s4 <= valid_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			last_s3  <= req_s2.last;
			sum_s3   <= sum;
			recip_s3 <= bda_pkg::recip(n);
			last_s4  <= last_s3;
			for (int k = 0; k < bda_pkg::NCHAN; k++) begin
				quo_s4[k] <= prod[k][bda_pkg::RSHIFT +: bda_pkg::CHAN_W];
			end
		end
	end

	assign res_valid = valid_s4;
	assign res_last  = last_s4;
	assign res_data  = quo_s4;

endmodule

[rtl/box_downsample_average.sv]
// ----------------------------------------------------------------------------
// box_downsample_average
// Shrinks an RGB raster stream by averaging whole n-by-n pixel blocks.
// ----------------------------------------------------------------------------
// One pixel is taken per clock whenever the output register is free or being
// drained; the block stalls only when a finished result sits unread. The
// result of the pixel that completes a block passes from the request register
// through accumulator stages s2, s3, s4 to the output register. Each block
// column update is one read and one write of the 4096-entry column sum store,
// which needs no clearing pass: the first row of every band overwrites the
// entries later rows read. Writes to the three registers restart the frame.
module box_downsample_average (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [23:0] s_axis_tdata,   // in_red, in_green, in_blue
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [23:0] m_axis_tdata,   // out_red, out_green, out_blue
	output logic        m_axis_tlast,   // frame_last
	input  logic        cfg_we,
	input  logic [1:0]  cfg_index,
	input  logic [12:0] cfg_data
);

	localparam int unsigned SUM_W = bda_pkg::DIM_W + 1;

	// configuration
	logic [bda_pkg::FACT_W-1:0] scale_q;
	logic [bda_pkg::DIM_W-1:0]  width_q;
	logic [bda_pkg::DIM_W-1:0]  height_q;
	logic [bda_pkg::FACT_W-1:0] n_eff;
	logic [bda_pkg::DIM_W-1:0]  w_eff;
	logic [bda_pkg::DIM_W-1:0]  h_eff;
	logic                       cfg_hit;

	// raster position
	logic [bda_pkg::COL_W-1:0]   col_q;
	logic [bda_pkg::COL_W-1:0]   row_q;
	logic [bda_pkg::PHASE_W-1:0] ph_col_q;
	logic [bda_pkg::PHASE_W-1:0] ph_row_q;
	logic [bda_pkg::COL_W-1:0]   bc_q;
	logic [bda_pkg::DIM_W-1:0]   bcs_q;
	logic [bda_pkg::DIM_W-1:0]   brs_q;
	bda_pkg::hsum_t              hsum_q;
	bda_pkg::hsum_t              hsum_nxt;

	logic [SUM_W-1:0] n_ext;
	logic             col_fit, row_fit, in_blk;
	logic             col_end, row_ph_end, line_end, frame_end;
	logic             last_col, last_row;
	logic             adv, take;

	bda_pkg::req_t req_s1;
	logic          res_valid, res_last;
	bda_pkg::pix_t res_data;

	logic          out_valid_q;
	logic          out_last_q;
	bda_pkg::pix_t out_data_q;

	// clamp the registers into their working ranges
	always_comb begin
		if (scale_q == '0)
			n_eff = bda_pkg::FACT_W'(1);
		else if (scale_q > bda_pkg::FACT_W'(bda_pkg::MAX_FACTOR))
			n_eff = bda_pkg::FACT_W'(bda_pkg::MAX_FACTOR);
		else
			n_eff = scale_q;
		if (width_q == '0)
			w_eff = bda_pkg::DIM_W'(1);
		else if (width_q > bda_pkg::DIM_W'(bda_pkg::MAX_WIDTH))
			w_eff = bda_pkg::DIM_W'(bda_pkg::MAX_WIDTH);
		else
			w_eff = width_q;
		if (height_q == '0)
			h_eff = bda_pkg::DIM_W'(1);
		else if (height_q > bda_pkg::DIM_W'(bda_pkg::ROW_LIMIT))
			h_eff = bda_pkg::DIM_W'(bda_pkg::ROW_LIMIT);
		else
			h_eff = height_q;
	end

	// position decode: block fit, phase wraps and edges
	always_comb begin
		n_ext      = SUM_W'(n_eff);
		col_fit    = (SUM_W'(bcs_q) + n_ext) <= SUM_W'(w_eff);
		row_fit    = (SUM_W'(brs_q) + n_ext) <= SUM_W'(h_eff);
		in_blk     = col_fit && row_fit;
		col_end    = (bda_pkg::FACT_W'(ph_col_q) + 1'b1) >= n_eff;
		row_ph_end = (bda_pkg::FACT_W'(ph_row_q) + 1'b1) >= n_eff;
		line_end   = (bda_pkg::DIM_W'(col_q) + 1'b1) >= w_eff;
		frame_end  = (bda_pkg::DIM_W'(row_q) + 1'b1) >= h_eff;
		last_col   = (SUM_W'(bcs_q) + (n_ext << 1)) > SUM_W'(w_eff);
		last_row   = (SUM_W'(brs_q) + (n_ext << 1)) > SUM_W'(h_eff);
		for (int k = 0; k < bda_pkg::NCHAN; k++) begin
			hsum_nxt[k] = hsum_q[k]
				+ bda_pkg::HSUM_W'(s_axis_tdata[k*bda_pkg::CHAN_W +: bda_pkg::CHAN_W]);
		end
	end

	// handshake: the whole pipeline moves while the output register can take
	assign adv           = !out_valid_q || m_axis_tready;
	assign s_axis_tready = adv;
	assign take          = s_axis_tvalid && adv;

	// register decode
	always_comb begin
		unique case (bda_pkg::reg_idx_t'(cfg_index))
			bda_pkg::REG_SCALE,
			bda_pkg::REG_WIDTH,
			bda_pkg::REG_HEIGHT: cfg_hit = cfg_we;
			default:             cfg_hit = 1'b0;
		endcase
	end

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			scale_q  <= bda_pkg::FACT_W'(2);
			width_q  <= bda_pkg::DIM_W'(640);
			height_q <= bda_pkg::DIM_W'(480);
		end else if (cfg_we) begin
			unique case (bda_pkg::reg_idx_t'(cfg_index))
				bda_pkg::REG_SCALE:  scale_q  <= cfg_data[bda_pkg::FACT_W-1:0];
				bda_pkg::REG_WIDTH:  width_q  <= cfg_data;
				bda_pkg::REG_HEIGHT: height_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// raster counters and the running horizontal sum
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q    <= '0;
			row_q    <= '0;
			ph_col_q <= '0;
			ph_row_q <= '0;
			bc_q     <= '0;
			bcs_q    <= '0;
			brs_q    <= '0;
			hsum_q   <= '0;
		end else if (cfg_hit) begin
			col_q    <= '0;
			row_q    <= '0;
			ph_col_q <= '0;
			ph_row_q <= '0;
			bc_q     <= '0;
			bcs_q    <= '0;
			brs_q    <= '0;
			hsum_q   <= '0;
		end else if (take) begin
			if (in_blk) begin
				hsum_q <= col_end ? '0 : hsum_nxt;
			end
			if (line_end) begin
				col_q    <= '0;
				ph_col_q <= '0;
				bc_q     <= '0;
				bcs_q    <= '0;
				hsum_q   <= '0;
				if (frame_end) begin
					row_q    <= '0;
					ph_row_q <= '0;
					brs_q    <= '0;
				end else begin
					row_q <= row_q + 1'b1;
					if (row_ph_end) begin
						ph_row_q <= '0;
						brs_q    <= brs_q + bda_pkg::DIM_W'(n_eff);
					end else begin
						ph_row_q <= ph_row_q + 1'b1;
					end
				end
			end else begin
				col_q <= col_q + 1'b1;
				if (col_end) begin
					ph_col_q <= '0;
					bc_q     <= bc_q + 1'b1;
					bcs_q    <= bcs_q + bda_pkg::DIM_W'(n_eff);
				end else begin
					ph_col_q <= ph_col_q + 1'b1;
				end
			end
		end
	end

	// line store update for a pixel that closes a block column
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			req_s1 <= '0;
		end else if (adv) begin
			req_s1.valid <= take && in_blk && col_end;
			req_s1.addr  <= bc_q;
			req_s1.first <= ph_row_q == '0;
			req_s1.emit  <= row_ph_end;
			req_s1.last  <= last_col && last_row;
			req_s1.hsum  <= hsum_nxt;
		end
	end

	bda_accum u_accum (
		.clk       (clk),
		.arst_n    (arst_n),
		.adv       (adv),
		.req       (req_s1),
		.n         (n_eff),
		.res_valid (res_valid),
		.res_last  (res_last),
		.res_data  (res_data)
	);

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv) begin
			out_valid_q <= res_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			out_last_q <= res_last;
			out_data_q <= res_data;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tlast  = out_last_q;
	assign m_axis_tdata  = out_data_q;

	// phases stay inside the current block edge
	assert property (@(posedge clk) disable iff (!arst_n)
		(bda_pkg::FACT_W'(ph_col_q) < n_eff) && (bda_pkg::FACT_W'(ph_row_q) < n_eff))
		else $error("block phase out of range");

	// the start of the current block column never runs ahead of the pixel column
	assert property (@(posedge clk) disable iff (!arst_n)
		bcs_q <= bda_pkg::DIM_W'(col_q))
		else $error("block column start ahead of pixel column");

	// the last pixel of a frame returns the raster to its origin
	assert property (@(posedge clk) disable iff (!arst_n)
		take && line_end && frame_end && !cfg_hit |=> col_q == '0 && row_q == '0)
		else $error("raster did not wrap at frame end");

endmodule

[tb/tb_top.sv]
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the n-by-n box downsampler. Raster pixels go in
// through the input stream, block averages are predicted per pixel from a
// behavioral copy of the line store and raster counters, and every result
// transaction is compared with the oldest prediction. Directed frames cover
// value extremes, register clamping, frame restarts and blocks that never
// fit; random frames of random geometry follow.
// ----------------------------------------------------------------------------
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;

	// register index outside the register list, written to check it is ignored
	localparam logic [1:0] REG_UNUSED = 2'd3;

	localparam int unsigned SETTLE_CYCLES = 12;
	localparam int unsigned DRAIN_LIMIT   = 5000;
	localparam int unsigned RANDOM_ITEMS  = 300;
	localparam int unsigned MAX_SHOWN     = 10;

	// packed so that red lands in the lowest byte of tdata
	typedef struct packed {
		logic [7:0] blue;
		logic [7:0] green;
		logic [7:0] red;
	} rgb_t;

	typedef struct packed {
		logic frame_last;
		rgb_t rgb;
	} block_avg_t;

	logic        clk = 1'b0;
	logic        arst_n;
	logic        s_axis_tvalid;
	logic        s_axis_tready;
	logic [23:0] s_axis_tdata;   // in_red, in_green, in_blue
	logic        m_axis_tvalid;
	logic        m_axis_tready;
	logic [23:0] m_axis_tdata;   // out_red, out_green, out_blue
	logic        m_axis_tlast;   // frame_last
	logic        cfg_we;
	logic [1:0]  cfg_index;
	logic [12:0] cfg_data;

	// idling control shared by the stream drivers
	bit          src_idle = 1'b1;
	bit          sink_idle = 1'b1;
	int unsigned hold_off_cycles = 0;

	// predicted block averages waiting for their result transaction
	block_avg_t  pending_blocks [$];
	int unsigned err_count = 0;
	int unsigned blocks_seen = 0;

	// predictor copy of the registers and the raster state
	logic [4:0]        geo_factor;
	logic [12:0]       geo_width;
	logic [12:0]       geo_height;
	logic [2:0][15:0]  band_sum [bda_pkg::MAX_WIDTH];
	int unsigned       run_sum [3];
	int unsigned       at_col, at_row, sub_col, sub_row;

	box_downsample_average u_top (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tlast  (m_axis_tlast),
		.cfg_we        (cfg_we),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data)
	);

	always #4 clk = ~clk;

	// ------------------------------------------------------------------
	// predictor
	// ------------------------------------------------------------------

	function automatic int unsigned fit_range(input int unsigned v, input int unsigned hi);
		if (v == 0) return 1;
		if (v > hi) return hi;
		return v;
	endfunction

	function automatic void rewind_raster();
		run_sum = '{default: 0};
		at_col  = 0;
		at_row  = 0;
		sub_col = 0;
		sub_row = 0;
	endfunction

	function automatic void apply_reg(input logic [1:0] idx, input logic [12:0] val);
		case (idx)
			bda_pkg::REG_SCALE:  geo_factor = val[4:0];
			bda_pkg::REG_WIDTH:  geo_width  = val;
			bda_pkg::REG_HEIGHT: geo_height = val;
			default:             return;
		endcase
		rewind_raster();
	endfunction

	// one pixel in, at most one finished block out
	function automatic void predict_block(input rgb_t px, output bit made,
			output block_avg_t want);
		int unsigned n, w, h, ow, oh, bc, area;
		int unsigned chan [3];
		made = 1'b0;
		want = '0;
		n  = fit_range(geo_factor, bda_pkg::MAX_FACTOR);
		w  = fit_range(geo_width, bda_pkg::MAX_WIDTH);
		h  = fit_range(geo_height, bda_pkg::ROW_LIMIT);
		ow = w / n;
		oh = h / n;
		chan[0] = px.red;
		chan[1] = px.green;
		chan[2] = px.blue;

		// leftover columns and rows fall outside every block
		if (at_col < ow * n && at_row < oh * n) begin
			for (int k = 0; k < 3; k++) run_sum[k] += chan[k];
			if (sub_col + 1 >= n) begin
				bc = at_col / n;
				// first row of a band overwrites, later rows accumulate
				for (int k = 0; k < 3; k++) begin
					if (sub_row == 0) band_sum[bc][k] = 16'(run_sum[k]);
					else band_sum[bc][k] = band_sum[bc][k] + 16'(run_sum[k]);
				end
				if (sub_row + 1 >= n) begin
					area = n * n;
					want.rgb.red    = 8'(band_sum[bc][0] / area);
					want.rgb.green  = 8'(band_sum[bc][1] / area);
					want.rgb.blue   = 8'(band_sum[bc][2] / area);
					want.frame_last = (bc + 1 == ow) && (at_row / n + 1 == oh);
					made = 1'b1;
				end
				run_sum = '{default: 0};
			end
		end

		// raster position, wrapping at the end of the frame
		if (at_col + 1 >= w) begin
			at_col  = 0;
			sub_col = 0;
			run_sum = '{default: 0};
			if (at_row + 1 >= h) begin
				at_row  = 0;
				sub_row = 0;
			end else begin
				at_row++;
				sub_row = (sub_row + 1 >= n) ? 0 : sub_row + 1;
			end
		end else begin
			at_col++;
			sub_col = (sub_col + 1 >= n) ? 0 : sub_col + 1;
		end
	endfunction

	function automatic void flag_error(input string msg);
		err_count++;
		if (err_count <= MAX_SHOWN) $display("%0t: %s", $time, msg);
	endfunction

	// ------------------------------------------------------------------
	// scoreboard: register writes, input and result transactions
	// ------------------------------------------------------------------
	always @(posedge clk or negedge arst_n) begin : scoreboard
		block_avg_t want;
		block_avg_t got;
		bit         made;
		if (!arst_n) begin
			geo_factor = 5'd2;
			geo_width  = 13'd640;
			geo_height = 13'd480;
			rewind_raster();
		end else begin
			if (cfg_we) apply_reg(cfg_index, cfg_data);

			if (s_axis_tvalid && s_axis_tready) begin
				predict_block(rgb_t'(s_axis_tdata), made, want);
				if (made) pending_blocks.push_back(want);
			end

			if (m_axis_tvalid && m_axis_tready) begin
				got.rgb        = rgb_t'(m_axis_tdata);
				got.frame_last = m_axis_tlast;
				if (pending_blocks.size() == 0) begin
					flag_error($sformatf("unexpected block rgb %0d/%0d/%0d last %0b",
						got.rgb.red, got.rgb.green, got.rgb.blue, got.frame_last));
				end else begin
					want = pending_blocks.pop_front();
					if (got.rgb.red != want.rgb.red || got.rgb.green != want.rgb.green ||
							got.rgb.blue != want.rgb.blue ||
							got.frame_last != want.frame_last)
						flag_error($sformatf(
							"block %0d: expected rgb %0d/%0d/%0d last %0b, got %0d/%0d/%0d last %0b",
							blocks_seen, want.rgb.red, want.rgb.green, want.rgb.blue,
							want.frame_last, got.rgb.red, got.rgb.green, got.rgb.blue,
							got.frame_last));
				end
				blocks_seen++;
			end
		end
	end

	// ------------------------------------------------------------------
	// result side: random ready gaps, plus a long hold-off on request
	// ------------------------------------------------------------------
	initial begin : result_sink
		int unsigned gap;
		m_axis_tready = 1'b0;
		wait (arst_n === 1'b1);
		@(posedge clk);
		forever begin
			if (hold_off_cycles != 0) begin
				m_axis_tready <= 1'b0;
				repeat (hold_off_cycles) @(posedge clk);
				hold_off_cycles = 0;
			end
			gap = sink_idle ? $urandom_range(0, 4) : 0;
			if (gap != 0) begin
				m_axis_tready <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			m_axis_tready <= 1'b1;
			do @(posedge clk); while (!(m_axis_tvalid && m_axis_tready));
		end
	end

	// ------------------------------------------------------------------
	// shared drivers
	// ------------------------------------------------------------------

	function automatic rgb_t mk_rgb(input logic [7:0] r, input logic [7:0] g,
			input logic [7:0] b);
		rgb_t p;
		p.red   = r;
		p.green = g;
		p.blue  = b;
		return p;
	endfunction

	// one pixel transaction; tvalid stays high on return
	task automatic send_pixel(input rgb_t px);
		int unsigned gap;
		gap = src_idle ? $urandom_range(0, 4) : 0;
		if (gap != 0) begin
			s_axis_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= px;
		do @(posedge clk); while (!s_axis_tready);
	endtask

	task automatic send_random(input int unsigned count);
		repeat (count) send_pixel(rgb_t'(24'($urandom())));
	endtask

	// stop the source, let every predicted block drain, then let the pipe empty
	task automatic settle();
		int unsigned waited;
		s_axis_tvalid <= 1'b0;
		waited = 0;
		do begin
			@(posedge clk);
			waited++;
		end while (pending_blocks.size() != 0 && waited < DRAIN_LIMIT);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(input logic [1:0] idx, input logic [12:0] val);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		@(posedge clk);
		cfg_we    <= 1'b0;
		@(posedge clk);
	endtask

	task automatic set_geometry(input logic [4:0] n, input logic [12:0] w,
			input logic [12:0] h);
		settle();
		write_reg(bda_pkg::REG_SCALE, 13'(n));
		write_reg(bda_pkg::REG_WIDTH, w);
		write_reg(bda_pkg::REG_HEIGHT, h);
	endtask

	// ------------------------------------------------------------------
	// tests
	// ------------------------------------------------------------------

	// reset geometry, 640 wide with factor 2: a partial row gives nothing,
	// then a narrowed width shows whole blocks of the reset factor
	task automatic test_reset_geometry();
		send_random(40);
		settle();
		write_reg(bda_pkg::REG_WIDTH, 13'd4);
		send_random(16);
		settle();
	endtask

	// zero factor acts as one: every pixel is its own block and 2x2 frames
	task automatic test_block_extremes();
		set_geometry(5'd0, 13'd2, 13'd2);
		send_pixel(mk_rgb(8'd0, 8'd0, 8'd0));
		send_pixel(mk_rgb(8'd255, 8'd255, 8'd255));
		send_pixel(mk_rgb(8'd255, 8'd0, 8'd0));
		send_pixel(mk_rgb(8'd0, 8'd170, 8'd255));
		settle();
	endtask

	// an out-of-range index must neither change a register nor restart
	task automatic test_register_index_ignored();
		set_geometry(5'd2, 13'd2, 13'd2);
		send_pixel(mk_rgb(8'd255, 8'd0, 8'd1));
		send_pixel(mk_rgb(8'd255, 8'd0, 8'd2));
		settle();
		write_reg(REG_UNUSED, 13'd1);
		send_pixel(mk_rgb(8'd255, 8'd0, 8'd3));
		send_pixel(mk_rgb(8'd255, 8'd0, 8'd4));
		settle();
	endtask

	// a register write part way into a frame starts a new one
	task automatic test_mid_frame_restart();
		set_geometry(5'd3, 13'd3, 13'd3);
		send_random(5);
		settle();
		write_reg(bda_pkg::REG_HEIGHT, 13'd3);
		// truncating divide by nine
		for (int k = 0; k < 9; k++)
			send_pixel(mk_rgb((k == 4) ? 8'd0 : 8'd255, 8'(8'd255 - k), 8'(k)));
		settle();
	endtask

	// factor above the limit saturates to 16; full-scale sums must not wrap
	task automatic test_factor_saturation();
		set_geometry(5'd31, 13'd16, 13'd16);
		repeat (256) send_pixel(mk_rgb(8'd255, 8'd255, 8'd255));
		settle();
	endtask

	// zero and oversized dimensions clamp to their limits
	task automatic test_size_limits();
		set_geometry(5'd1, 13'd0, 13'd0);
		send_random(6);
		set_geometry(5'd1, 13'd1, 13'h1FFF);
		send_random(40);
		set_geometry(5'd1, 13'h1FFF, 13'd1);
		send_random(20);
		set_geometry(5'd16, 13'd4096, 13'd4096);
		send_random(20);
		settle();
	endtask

	// no block fits, so nothing comes out while the counters keep wrapping
	task automatic test_factor_exceeds_size();
		set_geometry(5'd5, 13'd3, 13'd20);
		send_random(60);
		set_geometry(5'd8, 13'd20, 13'd4);
		send_random(80);
		settle();
	endtask

	// long result hold-off while the source keeps offering pixels
	task automatic test_output_stall();
		set_geometry(5'd1, 13'd8, 13'd8);
		src_idle        = 1'b0;
		sink_idle       = 1'b0;
		hold_off_cycles = 300;
		send_random(64);
		settle();
		src_idle  = 1'b1;
		sink_idle = 1'b1;
	endtask

	// random geometry; mostly whole frames, some cut short, some with no block
	task automatic test_random_frames();
		int unsigned sent, n, w, h, len, shape;
		sent = 0;
		while (sent < RANDOM_ITEMS) begin
			src_idle  = ($urandom_range(0, 3) != 0);
			sink_idle = ($urandom_range(0, 3) != 0);
			shape = $urandom_range(0, 9);
			if (shape == 0) begin
				// large blocks, kept to about one block per frame
				n = $urandom_range(9, 16);
				w = n + $urandom_range(0, 4);
				h = n + $urandom_range(0, 2);
				len = w * h;
			end else if (shape == 1) begin
				n = $urandom_range(3, 16);
				if ($urandom_range(0, 1) != 0) begin
					w = $urandom_range(1, n - 1);
					h = $urandom_range(1, 20);
				end else begin
					w = $urandom_range(1, 20);
					h = $urandom_range(1, n - 1);
				end
				len = $urandom_range(1, 40);
			end else begin
				n = $urandom_range(1, 5);
				w = n * $urandom_range(1, 6) + $urandom_range(0, n - 1);
				h = n * $urandom_range(1, 4) + $urandom_range(0, n - 1);
				len = w * h * $urandom_range(1, 2);
				// frame cut short before the next write restarts it
				if (shape == 2) len = $urandom_range(1, len);
			end
			// keep the random phase to its pixel budget
			if (len > RANDOM_ITEMS - sent) len = RANDOM_ITEMS - sent;
			set_geometry(5'(n), 13'(w), 13'(h));
			send_random(len);
			sent += len;
		end
		settle();
		src_idle  = 1'b1;
		sink_idle = 1'b1;
	endtask

	// ------------------------------------------------------------------
	// sequence
	// ------------------------------------------------------------------
	initial begin : run_tests
		arst_n        = 1'b0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata  = '0;
		cfg_we        = 1'b0;
		cfg_index     = bda_pkg::REG_SCALE;
		cfg_data      = '0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_reset_geometry();
		test_block_extremes();
		test_register_index_ignored();
		test_mid_frame_restart();
		test_factor_saturation();
		test_size_limits();
		test_factor_exceeds_size();
		test_output_stall();
		test_random_frames();

		settle();
		if (pending_blocks.size() != 0)
			flag_error($sformatf("%0d predicted blocks never came out",
				pending_blocks.size()));
		if (err_count == 0) begin
			$display("tb_top: PASS");
		end else begin
			$display("tb_top: FAIL");
		end
		$finish;
	end

	// watchdog
	initial begin : watchdog
		#5_000_000;
		$display("tb_top: FAIL");
		$finish;
	end

endmodule

[sim.f]
rtl/bda_pkg.sv
rtl/bda_accum.sv
rtl/box_downsample_average.sv
tb/tb_top.sv
